/* rtl/core/euler_to_rotation_matrix_top_defines.svh */
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_top_defines
// assertion macros shared by the rotation matrix block
// ----------------------------------------------------------------------------
`ifndef EULER_TO_ROTATION_MATRIX_TOP_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_TOP_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define E2R_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define E2R_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/e2r_pkg.sv */
// ----------------------------------------------------------------------------
// e2r_pkg
// shared types, constants and arithmetic helpers of the rotation matrix block
// ----------------------------------------------------------------------------
package e2r_pkg;

    // default configuration
    localparam int unsigned DEF_ANGLE_FRAC_BITS = 7;
    localparam int unsigned DEF_COEF_FRAC_BITS  = 16;
    localparam int unsigned DEF_TRIG_ITERATIONS = 18;

    // field and datapath widths
    localparam int unsigned FIELD_W     = 18;
    localparam int unsigned ANG_W       = 18;
    localparam int unsigned CW          = 33;
    localparam int unsigned TW          = 32;
    localparam int unsigned MAT_ENTRIES = 9;
    localparam int unsigned ATAN_DEPTH  = 32;

    // cordic start value: inverse of the limit gain in q2.30
    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 33'sh026DD3B6A;
    localparam logic signed [TW-1:0] ONE_Q30 = 32'sh40000000;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [ATAN_DEPTH] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // quadrant codes
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef logic signed [CW-1:0] cordic_t;
    typedef logic signed [TW-1:0] trig_t;
    typedef logic [MAT_ENTRIES-1:0][FIELD_W-1:0] mat_t;
    typedef logic [63:0][31:0] frac_tab_t;

    // pipeline control passed to every stage group
    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctrl_t;

    // constant table: fraction of a 45th part in turn units on a 6 bit index
    function automatic frac_tab_t frac_table(input int unsigned sh);
        frac_tab_t t;
        longint unsigned n;
        for (int v = 0; v < 64; v++) begin
            n = longint'(v) << sh;
            t[v] = 32'(n / 45);
        end
        return t;
    endfunction

    // clamp to plus or minus one in q2.30
    function automatic trig_t clamp_one(input cordic_t v);
        trig_t r;
        if (v > CW'(ONE_Q30)) begin
            r = ONE_Q30;
        end else if (v < -CW'(ONE_Q30)) begin
            r = -ONE_Q30;
        end else begin
            r = TW'(v);
        end
        return r;
    endfunction

    // rounded q2.30 product
    function automatic trig_t mul_q30(input trig_t a, input trig_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sh20000000;
        return TW'(p >>> 30);
    endfunction

endpackage

/* rtl/core/e2r_reduce.sv */
// ----------------------------------------------------------------------------
// e2r_reduce
// reduces an angle modulo 360 degrees into a quadrant and a cordic phase
// ----------------------------------------------------------------------------
module e2r_reduce #(
    parameter int unsigned ANGLE_FRAC_BITS = e2r_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  e2r_pkg::pipe_ctrl_t                ctrl_i,
    input  logic signed [e2r_pkg::ANG_W-1:0]   angle_i,
    output logic                               vld_o,
    output e2r_pkg::quad_t                     quad_o,
    output e2r_pkg::cordic_t                   phase_o
);
    import e2r_pkg::*;

    localparam int unsigned FULL    = 360 << ANGLE_FRAC_BITS;
    localparam int unsigned QUARTER = FULL / 4;
    localparam int unsigned NOFF    = (131072 + FULL - 1) / FULL;
    localparam int unsigned OFF     = NOFF * FULL;
    localparam int unsigned NMUL    = 2 * NOFF;
    localparam int unsigned VW      = 22;
    localparam int unsigned RW      = 19;
    localparam int unsigned UW      = 14;
    localparam int unsigned SH      = 29 - ANGLE_FRAC_BITS;
    localparam int unsigned RECIP   = 1491309;
    localparam int unsigned RSH     = 26;
    localparam frac_tab_t   FRAC_TAB = frac_table(SH);

    logic [VW-1:0]     wrap_val;
    logic [VW-1:0]     mod_next;
    logic [VW-1:0]     mod_reg;
    logic              v1_reg;
    quad_t             quad_next;
    logic [RW-1:0]     rem_next;
    quad_t             q2_reg;
    logic [RW-1:0]     r2_reg;
    logic              v2_reg;
    logic [RW+21:0]    recip_prod;
    logic [UW-1:0]     u3_reg;
    logic [RW-1:0]     r3_reg;
    quad_t             q3_reg;
    logic              v3_reg;
    logic [RW-1:0]     u45;
    logic [RW-1:0]     v_full;
    logic [31:0]       phase_next;
    cordic_t           phase_reg;
    quad_t             q4_reg;
    logic              v4_reg;

    // stage 1: bring the angle into one turn by compare and subtract
    always_comb begin
        wrap_val = VW'(signed'(angle_i)) + VW'(OFF);
        mod_next = wrap_val;
        for (int j = 1; j <= int'(NMUL); j++) begin
            if (wrap_val >= VW'(j * FULL)) begin
                mod_next = wrap_val - VW'(j * FULL);
            end
        end
    end

    // stage 2: quadrant and remainder within the quadrant
    always_comb begin
        if (mod_reg >= VW'(3 * QUARTER)) begin
            quad_next = QUAD_3;
            rem_next  = RW'(mod_reg - VW'(3 * QUARTER));
        end else if (mod_reg >= VW'(2 * QUARTER)) begin
            quad_next = QUAD_2;
            rem_next  = RW'(mod_reg - VW'(2 * QUARTER));
        end else if (mod_reg >= VW'(QUARTER)) begin
            quad_next = QUAD_1;
            rem_next  = RW'(mod_reg - VW'(QUARTER));
        end else begin
            quad_next = QUAD_0;
            rem_next  = RW'(mod_reg);
        end
    end

    // stage 3: remainder divided by 45 through a reciprocal product
    assign recip_prod = (RW+22)'(r2_reg) * (RW+22)'(RECIP);

    // stage 4: phase in turn units from quotient and leftover
    always_comb begin
        u45        = RW'(RW'(u3_reg) * RW'(45));
        v_full     = r3_reg - u45;
        phase_next = (32'(u3_reg) << SH) | FRAC_TAB[v_full[5:0]];
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (ctrl_i.en) begin
            v1_reg <= ctrl_i.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.en) begin
            mod_reg   <= mod_next;
            q2_reg    <= quad_next;
            r2_reg    <= rem_next;
            u3_reg    <= recip_prod[RSH +: UW];
            r3_reg    <= r2_reg;
            q3_reg    <= q2_reg;
            phase_reg <= cordic_t'({1'b0, phase_next});
            q4_reg    <= q3_reg;
        end
    end

    assign vld_o   = v4_reg;
    assign quad_o  = q4_reg;
    assign phase_o = phase_reg;

endmodule

/* rtl/core/e2r_cordic.sv */
// ----------------------------------------------------------------------------
// e2r_cordic
// rotation mode cordic, one micro-rotation per pipeline stage
// ----------------------------------------------------------------------------
module e2r_cordic #(
    parameter int unsigned TRIG_ITERATIONS = e2r_pkg::DEF_TRIG_ITERATIONS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  e2r_pkg::pipe_ctrl_t  ctrl_i,
    input  e2r_pkg::quad_t       quad_i,
    input  e2r_pkg::cordic_t     phase_i,
    output logic                 vld_o,
    output e2r_pkg::quad_t       quad_o,
    output e2r_pkg::cordic_t     x_o,
    output e2r_pkg::cordic_t     y_o
);
    import e2r_pkg::*;

    localparam int unsigned NIT = (TRIG_ITERATIONS < ATAN_DEPTH) ? TRIG_ITERATIONS : ATAN_DEPTH;

    cordic_t x_st [NIT+1];
    cordic_t y_st [NIT+1];
    cordic_t z_st [NIT+1];
    quad_t   q_st [NIT+1];
    logic    v_st [NIT+1];

    // stage inputs
    assign x_st[0] = CORDIC_GAIN_INV;
    assign y_st[0] = '0;
    assign z_st[0] = phase_i;
    assign q_st[0] = quad_i;
    assign v_st[0] = ctrl_i.vld;

    for (genvar i = 0; i < NIT; i++) begin : g_iter
        localparam cordic_t ATAN_I = cordic_t'({1'b0, ATAN_TURNS[i]});
        cordic_t dx;
        cordic_t dy;

        assign dx = y_st[i] >>> i;
        assign dy = x_st[i] >>> i;

        // micro-rotation in the direction of the remaining phase
        always_ff @(posedge aclk) begin
            if (ctrl_i.en) begin
                q_st[i+1] <= q_st[i];
                if (!z_st[i][CW-1]) begin
                    x_st[i+1] <= x_st[i] - dx;
                    y_st[i+1] <= y_st[i] + dy;
                    z_st[i+1] <= z_st[i] - ATAN_I;
                end else begin
                    x_st[i+1] <= x_st[i] + dx;
                    y_st[i+1] <= y_st[i] - dy;
                    z_st[i+1] <= z_st[i] + ATAN_I;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_st[i+1] <= 1'b0;
            end else if (ctrl_i.en) begin
                v_st[i+1] <= v_st[i];
            end
        end
    end

    assign vld_o  = v_st[NIT];
    assign quad_o = q_st[NIT];
    assign x_o    = x_st[NIT];
    assign y_o    = y_st[NIT];

endmodule

/* rtl/core/e2r_matrix.sv */
// ----------------------------------------------------------------------------
// e2r_matrix
// quadrant mapping, products and rounding of the nine matrix entries
// ----------------------------------------------------------------------------
module e2r_matrix #(
    parameter int unsigned COEF_FRAC_BITS = e2r_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  e2r_pkg::pipe_ctrl_t  ctrl_i,
    input  e2r_pkg::quad_t       quad_i [3],
    input  e2r_pkg::cordic_t     x_i    [3],
    input  e2r_pkg::cordic_t     y_i    [3],
    output logic                 vld_o,
    output e2r_pkg::mat_t        mat_o
);
    import e2r_pkg::*;

    localparam int unsigned EW  = TW + 2;
    localparam int unsigned SH  = 30 - COEF_FRAC_BITS;
    localparam longint      RND = (SH > 0) ? (longint'(1) << (SH - 1)) : 0;
    localparam longint      LIM = longint'(1) << COEF_FRAC_BITS;

    // index 0 roll, 1 yaw, 2 pitch
    trig_t cos_reg [3];
    trig_t sin_reg [3];
    logic  v0_reg, v1_reg, v2_reg, v3_reg;

    trig_t cycr_reg, sycr_reg, cysr_reg, srcp_reg, crcp_reg;
    trig_t srsy_reg, sycp_reg, cycp_reg, sysp_reg, cysp_reg;
    trig_t sr1_reg, cr1_reg, sp1_reg;

    trig_t cycr2_reg, sycr2_reg, cysr2_reg, srcp2_reg, crcp2_reg;
    trig_t srsy2_reg, sycp2_reg, cycp2_reg, sp2_reg;
    trig_t t1_reg, t2_reg, t3_reg, t4_reg;

    mat_t  mat_next;
    mat_t  mat_reg;

    // round half up and saturate one entry
    function automatic logic [FIELD_W-1:0] emit(input logic signed [EW-1:0] e);
        logic signed [EW-1:0] v;
        v = (e + EW'(RND)) >>> SH;
        if (v > EW'(LIM)) begin
            v = EW'(LIM);
        end else if (v < -EW'(LIM)) begin
            v = -EW'(LIM);
        end
        return v[FIELD_W-1:0];
    endfunction

    function automatic logic signed [EW-1:0] wide(input trig_t a);
        return EW'(a);
    endfunction

    // stage 0: quadrant map and clamp
    always_ff @(posedge aclk) begin
        if (ctrl_i.en) begin
            for (int k = 0; k < 3; k++) begin
                case (quad_i[k])
                    QUAD_0: begin
                        cos_reg[k] <= clamp_one(x_i[k]);
                        sin_reg[k] <= clamp_one(y_i[k]);
                    end
                    QUAD_1: begin
                        cos_reg[k] <= clamp_one(-y_i[k]);
                        sin_reg[k] <= clamp_one(x_i[k]);
                    end
                    QUAD_2: begin
                        cos_reg[k] <= clamp_one(-x_i[k]);
                        sin_reg[k] <= clamp_one(-y_i[k]);
                    end
                    default: begin
                        cos_reg[k] <= clamp_one(y_i[k]);
                        sin_reg[k] <= clamp_one(-x_i[k]);
                    end
                endcase
            end
        end
    end

    // stage 1: pairwise products
    always_ff @(posedge aclk) begin
        if (ctrl_i.en) begin
            cycr_reg <= mul_q30(cos_reg[1], cos_reg[0]);
            sycr_reg <= mul_q30(sin_reg[1], cos_reg[0]);
            cysr_reg <= mul_q30(cos_reg[1], sin_reg[0]);
            srcp_reg <= mul_q30(sin_reg[0], cos_reg[2]);
            crcp_reg <= mul_q30(cos_reg[0], cos_reg[2]);
            srsy_reg <= mul_q30(sin_reg[0], sin_reg[1]);
            sycp_reg <= mul_q30(sin_reg[1], cos_reg[2]);
            cycp_reg <= mul_q30(cos_reg[1], cos_reg[2]);
            sysp_reg <= mul_q30(sin_reg[1], sin_reg[2]);
            cysp_reg <= mul_q30(cos_reg[1], sin_reg[2]);
            sr1_reg  <= sin_reg[0];
            cr1_reg  <= cos_reg[0];
            sp1_reg  <= sin_reg[2];
        end
    end

    // stage 2: triple products
    always_ff @(posedge aclk) begin
        if (ctrl_i.en) begin
            t1_reg    <= mul_q30(sysp_reg, sr1_reg);
            t2_reg    <= mul_q30(sysp_reg, cr1_reg);
            t3_reg    <= mul_q30(cysp_reg, sr1_reg);
            t4_reg    <= mul_q30(cysp_reg, cr1_reg);
            cycr2_reg <= cycr_reg;
            sycr2_reg <= sycr_reg;
            cysr2_reg <= cysr_reg;
            srcp2_reg <= srcp_reg;
            crcp2_reg <= crcp_reg;
            srsy2_reg <= srsy_reg;
            sycp2_reg <= sycp_reg;
            cycp2_reg <= cycp_reg;
            sp2_reg   <= sp1_reg;
        end
    end

    // stage 3: sums, rounding and saturation
    always_comb begin
        mat_next[0] = emit(wide(cycr2_reg) + wide(t1_reg));
        mat_next[1] = emit(wide(srcp2_reg));
        mat_next[2] = emit(wide(t3_reg) - wide(sycr2_reg));
        mat_next[3] = emit(wide(t2_reg) - wide(cysr2_reg));
        mat_next[4] = emit(wide(crcp2_reg));
        mat_next[5] = emit(wide(srsy2_reg) + wide(t4_reg));
        mat_next[6] = emit(wide(sycp2_reg));
        mat_next[7] = emit(-wide(sp2_reg));
        mat_next[8] = emit(wide(cycp2_reg));
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.en) begin
            mat_reg <= mat_next;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (ctrl_i.en) begin
            v0_reg <= ctrl_i.vld;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign vld_o = v3_reg;
    assign mat_o = mat_reg;

endmodule

/* rtl/core/euler_to_rotation_matrix_top.sv */
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_top
// euler angles in degrees to a 3x3 rotation matrix, fully pipelined
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | roll, yaw, pitch angles (18 bit signed each)
//  m_axis   | out       | nine matrix entries, signed q1.16 (18 bit each)
//
//  one item per cycle sustained unless the buffer is full and held; stages
//  are 4 reduction, one cordic per iteration (min(TRIG_ITERATIONS, 32)), 4
//  matrix and the output buffer; the cordic iterations dominate the count.
//  synchronous active-low reset clears valid bits and the output buffer.
//  a two entry output buffer keeps input flowing while a result waits; the
//  pipeline halts as a whole only when the buffer is full and not drained.
// ----------------------------------------------------------------------------
`include "euler_to_rotation_matrix_top_defines.svh"

module euler_to_rotation_matrix_top #(
    parameter int unsigned ANGLE_FRAC_BITS = e2r_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int unsigned COEF_FRAC_BITS  = e2r_pkg::DEF_COEF_FRAC_BITS,
    parameter int unsigned TRIG_ITERATIONS = e2r_pkg::DEF_TRIG_ITERATIONS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // roll_angle [17:0], yaw_angle [35:18], pitch_angle [53:36]
    input  logic [55:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // col0_row0, col0_row1, col0_row2, col1_row0, col1_row1, col1_row2,
    // col2_row0, col2_row1, col2_row2, 18 bits each from bit 0 up
    output logic [167:0] m_tdata
);
    import e2r_pkg::*;

    logic        en;
    pipe_ctrl_t  red_ctrl [3];
    logic        red_vld  [3];
    quad_t       red_quad [3];
    cordic_t     red_phase[3];
    pipe_ctrl_t  cor_ctrl [3];
    logic        cor_vld  [3];
    quad_t       cor_quad [3];
    cordic_t     cor_x    [3];
    cordic_t     cor_y    [3];
    pipe_ctrl_t  mat_ctrl;
    logic        mat_vld;
    mat_t        mat;

    mat_t        slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    logic        pop;

    // pipeline advances unless the output buffer is full and held
    assign en       = (cnt_reg != 2'd2) || m_tready;
    assign s_tready = en;

    // one reduction and cordic lane per angle
    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign red_ctrl[k] = '{en: en, vld: s_tvalid};
        assign cor_ctrl[k] = '{en: en, vld: red_vld[k]};

        e2r_reduce #(
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
        ) u_reduce (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl_i  (red_ctrl[k]),
            .angle_i (signed'(s_tdata[k*ANG_W +: ANG_W])),
            .vld_o   (red_vld[k]),
            .quad_o  (red_quad[k]),
            .phase_o (red_phase[k])
        );

        e2r_cordic #(
            .TRIG_ITERATIONS (TRIG_ITERATIONS)
        ) u_cordic (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl_i  (cor_ctrl[k]),
            .quad_i  (red_quad[k]),
            .phase_i (red_phase[k]),
            .vld_o   (cor_vld[k]),
            .quad_o  (cor_quad[k]),
            .x_o     (cor_x[k]),
            .y_o     (cor_y[k])
        );
    end

    assign mat_ctrl = '{en: en, vld: cor_vld[0]};

    e2r_matrix #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_matrix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl_i  (mat_ctrl),
        .quad_i  (cor_quad),
        .x_i     (cor_x),
        .y_i     (cor_y),
        .vld_o   (mat_vld),
        .mat_o   (mat)
    );

    // output buffer bookkeeping
    assign push = en && mat_vld;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= mat;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {6'b0, slot_reg[rd_ptr_reg]};

    // checks on buffer and pipeline control
    `E2R_ASSERT_ALWAYS(a_cnt_range, cnt_reg != 2'd3, "output buffer count out of range")
    `E2R_ASSERT_ALWAYS(a_stall_full, s_tready || (cnt_reg == 2'd2), "stall without full buffer")
    `E2R_ASSERT_NEXT(a_push_shown, push && (cnt_reg == 2'd0), m_tvalid, "result transfer lost")
    `E2R_ASSERT_NEXT(a_full_hold, (cnt_reg == 2'd2) && !m_tready, cnt_reg == 2'd2, "buffer dropped an entry")

endmodule

/* tb/e2r_checker.sv */
// ----------------------------------------------------------------------------
// e2r_checker
// watches both channels, predicts each rotation matrix and compares entries
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module e2r_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [55:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [167:0] m_tdata,
    output int           fail_count,
    output int           pending_count
);
    import e2r_pkg::*;

    localparam int AFB = DEF_ANGLE_FRAC_BITS;
    localparam int CFB = DEF_COEF_FRAC_BITS;
    localparam longint Q30 = 64'sd1 << 30;

    logic [167:0] matrix_queue [$];

    function automatic longint asr64(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_q30(longint v);
        if (v > Q30) return Q30;
        if (v < -Q30) return -Q30;
        return v;
    endfunction

    // cosine and sine of one angle field in q2.30
    function automatic void angle_trig(input logic [17:0] raw, output longint cv,
                                       output longint sv);
        longint full, quarter, a, q, r, z, x, y, dx, dy, c, s;
        full = 64'sd360 << AFB;
        quarter = full / 4;
        a = ((longint'($signed(raw)) % full) + full) % full;
        q = a / quarter;
        r = a - q * quarter;
        z = (r <<< 32) / full;
        x = longint'(CORDIC_GAIN_INV);
        y = 0;
        for (int i = 0; i < DEF_TRIG_ITERATIONS && i < 32; i++) begin
            dx = asr64(y, i);
            dy = asr64(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
            end
        end
        case (quad_t'(q[1:0]))
            QUAD_0: begin c = x;  s = y;  end
            QUAD_1: begin c = -y; s = x;  end
            QUAD_2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        cv = clamp_q30(c);
        sv = clamp_q30(s);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return asr64(a * b + (64'sd1 << 29), 30);
    endfunction

    function automatic logic [17:0] to_coef(longint e);
        longint v, lim;
        lim = 64'sd1 << CFB;
        v = e;
        if (CFB < 30) v = asr64(e + (64'sd1 << (29 - CFB)), 30 - CFB);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[17:0];
    endfunction

    function automatic logic [167:0] rotation_matrix(logic [55:0] d);
        longint cr, sr, cy, sy, cp, sp, sysp, cysp;
        logic [167:0] m;
        angle_trig(d[17:0], cr, sr);
        angle_trig(d[35:18], cy, sy);
        angle_trig(d[53:36], cp, sp);
        sysp = qmul(sy, sp);
        cysp = qmul(cy, sp);
        m = '0;
        m[17:0]    = to_coef(qmul(cy, cr) + qmul(sysp, sr));
        m[35:18]   = to_coef(qmul(sr, cp));
        m[53:36]   = to_coef(-qmul(sy, cr) + qmul(cysp, sr));
        m[71:54]   = to_coef(-qmul(cy, sr) + qmul(sysp, cr));
        m[89:72]   = to_coef(qmul(cr, cp));
        m[107:90]  = to_coef(qmul(sr, sy) + qmul(cysp, cr));
        m[125:108] = to_coef(qmul(sy, cp));
        m[143:126] = to_coef(-sp);
        m[161:144] = to_coef(qmul(cy, cp));
        return m;
    endfunction

    assign pending_count = matrix_queue.size();

    // predict on input transfer, compare on output transfer
    always @(posedge aclk) begin
        logic [167:0] want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) matrix_queue.push_back(rotation_matrix(s_tdata));
            if (m_tvalid && m_tready) begin
                if (matrix_queue.size() == 0) begin
                    $error("unexpected matrix %h", m_tdata);
                    errs = 1;
                end else begin
                    want = matrix_queue.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        if (m_tdata[k*18 +: 18] !== want[k*18 +: 18]) begin
                            $error("col%0d_row%0d expected %h actual %h", k / 3, k % 3,
                                   want[k*18 +: 18], m_tdata[k*18 +: 18]);
                            errs++;
                        end
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
        end
    end
endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// angle stimulus with bursty input and stalling output, verdict at the end
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [55:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;
    int           fail_count;
    int           pending_count;
    int           cycle_count = 0;
    bit           hold_off = 1'b0;

    localparam int LIMIT = 200000;
    localparam int DRAIN = 80;

    euler_to_rotation_matrix_top i_dut (.*);

    e2r_checker i_checker (.*);

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        repeat (6) @(negedge aclk);
        forever begin
            @(negedge aclk);
            if (hold_off) m_tready <= 1'b0;
            else if (cycle_count < 60) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (cycle_count > 150);
        hold_off = 1'b1;
        repeat (100) @(posedge aclk);
        hold_off = 1'b0;
    end

    function automatic logic [17:0] rand_angle();
        case ($urandom_range(0, 4))
            0: return 18'($urandom_range(0, 4) * 90 * 128);
            1: return 18'(-($urandom_range(0, 10) * 45 * 128));
            2: return 18'($urandom_range(0, 3) == 0 ? 18'h1ffff : 18'h20000);
            default: return 18'($urandom);
        endcase
    endfunction

    // one input transfer
    task automatic send_angles(input logic [17:0] r, input logic [17:0] y,
                               input logic [17:0] p);
        s_tdata  <= {2'b00, p, y, r};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        logic [17:0] edge_vals [8];
        int burst;
        int gap;
        edge_vals = '{18'h00000, 18'h1ffff, 18'h20000, 18'h3ffff,
                      18'd11520, 18'd23040, 18'd46080, 18'h3d300};
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed: extremes, quadrant boundaries, wrap beyond a full turn
        for (int i = 0; i < 8; i++) send_angles(edge_vals[i], edge_vals[7-i], edge_vals[(i+3)%8]);
        for (int i = 0; i < 8; i++) send_angles(edge_vals[i], edge_vals[i], edge_vals[i]);
        send_angles(18'h2aaaa, 18'h15555, 18'h00001);
        // random bursts with gaps
        for (int n = 0; n < 400; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++, n++) send_angles(rand_angle(), rand_angle(), rand_angle());
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
